FILE: sv/lfu_pkg.sv
// Shared types and codes for the keyed LFU cache table.
// Holds the sequencer state type and the request codes; no dependencies.
package lfu_pkg;

    // Request codes carried on the input tuser
    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_DEL  = 2'd1;
    localparam logic [1:0] ACT_FIND = 2'd2;

    // Result status codes
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NOTFOUND = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

endpackage

FILE: sv/lfu_keyed_cache_table.sv
// Keyed table with least-frequently-used eviction, single module.
// Depends on lfu_pkg for the state type and the request codes.
//
// The table holds up to ENTRIES items, each with a 32-bit key, a 64-bit
// payload, a saturating popularity count of HIT_BITS bits and an age rank
// (0 = newest). A request arrives as one item on the slave stream: tuser
// carries the action (add, delete, find), tdata the key and the payload.
// A request is taken in the idle state. In the scan state a single compare
// unit then visits the slots in turn (key match with newest-first priority,
// or lowest popularity with ties to the newest, plus the first free slot),
// and the update state writes back the table and loads the result
// register. The slave side is ready only between requests. The result
// waits in an output register, so a new request can be taken and scanned
// while the previous result is still pending; the write-back cycle holds
// until that register is free. Add into a full table evicts the least
// popular entry and sets evicted; find and delete act on the newest match;
// a missing key or the unused action code returns status 1 with a zero
// payload. No clearing pass is needed after reset: only the valid bits
// and the entry count are cleared.
module lfu_keyed_cache_table #(
    parameter int ENTRIES  = 10,
    parameter int HIT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // [31:0] lookup_key, [95:32] payload_in
    input  logic [1:0]   s_axis_tuser,   // [1:0] action
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // [63:0] payload_out
    output logic [1:0]   m_axis_tuser    // [0] status, [1] evicted
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0]    FULL_CNT = CNT_W'(ENTRIES);
    localparam logic [HIT_BITS-1:0] HIT_MAX  = '1;

    // slot storage
    logic [ENTRIES-1:0]  r_valid;
    logic [31:0]         r_key   [ENTRIES];
    logic [63:0]         r_pay   [ENTRIES];
    logic [HIT_BITS-1:0] r_hits  [ENTRIES];
    logic [IDX_W-1:0]    r_rank  [ENTRIES];
    logic [CNT_W-1:0]    r_count;

    // request and scan registers
    lfu_pkg::t_state     r_state, n_state;
    logic [1:0]          r_act;
    logic [31:0]         r_req_key;
    logic [63:0]         r_req_pay;
    logic [IDX_W-1:0]    r_idx;
    logic                r_best_ok;
    logic [IDX_W-1:0]    r_best;
    logic [HIT_BITS-1:0] r_best_hits;
    logic [IDX_W-1:0]    r_best_rank;
    logic [63:0]         r_best_pay;
    logic                r_free_ok;
    logic [IDX_W-1:0]    r_free;

    // result register
    logic                r_out_valid;
    logic                r_out_status;
    logic                r_out_evict;
    logic [63:0]         r_out_pay;

    logic take_in;
    logic out_free;
    logic do_update;
    logic scan_v;
    logic [31:0]         scan_key;
    logic [HIT_BITS-1:0] scan_hits;
    logic [IDX_W-1:0]    scan_rank;
    logic hit_cand;
    logic match_cand;
    logic full;
    logic [IDX_W-1:0] ins_slot;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == lfu_pkg::S_IDLE);
    assign take_in       = s_axis_tvalid && s_axis_tready;
    assign do_update     = (r_state == lfu_pkg::S_UPDATE) && out_free;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pay;
    assign m_axis_tuser  = {r_out_evict, r_out_status};

    // the shared compare unit: looks at the one slot under the scan index
    assign scan_v    = r_valid[r_idx];
    assign scan_key  = r_key[r_idx];
    assign scan_hits = r_hits[r_idx];
    assign scan_rank = r_rank[r_idx];
    assign hit_cand  = scan_v && (!r_best_ok || scan_hits < r_best_hits ||
                       (scan_hits == r_best_hits && scan_rank < r_best_rank));
    assign match_cand = scan_v && (scan_key == r_req_key) &&
                        (!r_best_ok || scan_rank < r_best_rank);

    assign full     = (r_count == FULL_CNT);
    assign ins_slot = full ? r_best : r_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            lfu_pkg::S_IDLE: begin
                if (take_in) n_state = lfu_pkg::S_SCAN;
            end
            lfu_pkg::S_SCAN: begin
                if (r_idx == LAST_IDX) n_state = lfu_pkg::S_UPDATE;
            end
            lfu_pkg::S_UPDATE: begin
                if (out_free) n_state = lfu_pkg::S_IDLE;
            end
            default: n_state = lfu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // take the request, then scan one slot per cycle
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_act     <= s_axis_tuser;
            r_req_key <= s_axis_tdata[31:0];
            r_req_pay <= s_axis_tdata[95:32];
            r_idx     <= '0;
            r_best_ok <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_state == lfu_pkg::S_SCAN) begin
            if (r_idx != LAST_IDX) r_idx <= r_idx + 1'b1;
            if (r_act == lfu_pkg::ACT_ADD) begin
                if (!scan_v && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                    r_free    <= r_idx;
                end
                if (hit_cand) begin
                    r_best_ok   <= 1'b1;
                    r_best      <= r_idx;
                    r_best_hits <= scan_hits;
                    r_best_rank <= scan_rank;
                end
            end else if (match_cand) begin
                r_best_ok   <= 1'b1;
                r_best      <= r_idx;
                r_best_hits <= scan_hits;
                r_best_rank <= scan_rank;
                r_best_pay  <= r_pay[r_idx];
            end
        end
    end

    // write back the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (do_update) begin
            case (r_act)
                lfu_pkg::ACT_ADD: begin
                    if (!full) r_count <= r_count + 1'b1;
                    for (int j = 0; j < ENTRIES; j++) begin
                        if (IDX_W'(j) == ins_slot) begin
                            r_valid[j] <= 1'b1;
                            r_key[j]   <= r_req_key;
                            r_pay[j]   <= r_req_pay;
                            r_hits[j]  <= '0;
                            r_rank[j]  <= '0;
                        end else if (r_valid[j]) begin
                            // older than the evicted one: drop one, age one
                            if (!(full && r_rank[j] > r_best_rank))
                                r_rank[j] <= r_rank[j] + 1'b1;
                        end
                    end
                end
                lfu_pkg::ACT_DEL: begin
                    if (r_best_ok) begin
                        r_count <= r_count - 1'b1;
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (IDX_W'(j) == r_best) begin
                                r_valid[j] <= 1'b0;
                            end else if (r_valid[j] && r_rank[j] > r_best_rank) begin
                                r_rank[j] <= r_rank[j] - 1'b1;
                            end
                        end
                    end
                end
                lfu_pkg::ACT_FIND: begin
                    if (r_best_ok && r_best_hits != HIT_MAX)
                        r_hits[r_best] <= r_best_hits + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result register: load on write-back, hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_update) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_update) begin
            r_out_status <= lfu_pkg::ST_NOTFOUND;
            r_out_evict  <= 1'b0;
            r_out_pay    <= '0;
            case (r_act)
                lfu_pkg::ACT_ADD: begin
                    r_out_status <= lfu_pkg::ST_OK;
                    r_out_evict  <= full;
                end
                lfu_pkg::ACT_DEL: begin
                    if (r_best_ok) r_out_status <= lfu_pkg::ST_OK;
                end
                lfu_pkg::ACT_FIND: begin
                    if (r_best_ok) begin
                        r_out_status <= lfu_pkg::ST_OK;
                        r_out_pay    <= r_best_pay;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: tb/lfu_keyed_cache_table_tb.sv
// Self-checking testbench for the keyed LFU cache table.
// Depends on lfu_pkg and lfu_keyed_cache_table; keeps its own table predictor
// and compares every result item against it under random stream back-pressure.
module lfu_keyed_cache_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH = 10;
    localparam int HIT_W     = 16;
    localparam int RAND_ITEMS_PER_PHASE = 210;
    localparam int POPULAR_FINDS = 20;
    localparam int REPORT_LIMIT = 10;

    // The package names three request codes; the fourth must do nothing
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [31:0] KEY_MIN = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [HIT_W-1:0] HITS_FULL = {HIT_W{1'b1}};

    typedef struct packed {
        logic        status;
        logic [63:0] payload;
        logic        evicted;
    } t_lfu_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;   // [31:0] lookup_key, [95:32] payload_in
    logic [1:0]   s_axis_tuser = '0;   // [1:0] action
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;        // [63:0] payload_out
    logic [1:0]   m_axis_tuser;        // [0] status, [1] evicted

    lfu_keyed_cache_table #(
        .ENTRIES  (TBL_DEPTH),
        .HIT_BITS (HIT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the table, updated in request order at acceptance
    bit              tbl_valid   [TBL_DEPTH];
    logic [31:0]     tbl_key     [TBL_DEPTH];
    logic [63:0]     tbl_payload [TBL_DEPTH];
    logic [HIT_W-1:0] tbl_hits   [TBL_DEPTH];
    int unsigned     tbl_age     [TBL_DEPTH];
    int unsigned     tbl_fill;

    t_lfu_result pending_results[$];

    // Back-pressure knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned mismatch_count = 0;
    int unsigned result_count   = 0;
    int unsigned add_count      = 0;
    int unsigned evict_count    = 0;
    int unsigned hit_count      = 0;
    int unsigned miss_count     = 0;
    int unsigned unused_count   = 0;

    logic [31:0] key_pool[12];

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Generous ceiling; a full run under the heaviest stalls needs well under 0.5 ms
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still expected", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Newest occupied slot holding key, or -1
    function automatic int newest_match(logic [31:0] key);
        int best;
        best = -1;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (tbl_valid[i] && tbl_key[i] == key &&
                (best < 0 || tbl_age[i] < tbl_age[best]))
                best = i;
        end
        return best;
    endfunction

    // Free a slot and close the gap it leaves in the age ranks
    function automatic void drop_slot(int slot);
        tbl_valid[slot] = 1'b0;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (tbl_valid[i] && tbl_age[i] > tbl_age[slot])
                tbl_age[i]--;
        end
        if (tbl_fill > 0)
            tbl_fill--;
    endfunction

    function automatic t_lfu_result predict_request(logic [1:0] act, logic [31:0] key,
                                                    logic [63:0] pay);
        t_lfu_result res;
        int slot;
        res = '0;
        res.status = lfu_pkg::ST_NOTFOUND;
        case (act)
            lfu_pkg::ACT_ADD: begin
                if (tbl_fill >= TBL_DEPTH) begin
                    // Least popular entry goes; ties fall to the newest one
                    slot = -1;
                    for (int i = 0; i < TBL_DEPTH; i++) begin
                        if (tbl_valid[i] && (slot < 0 || tbl_hits[i] < tbl_hits[slot] ||
                            (tbl_hits[i] == tbl_hits[slot] && tbl_age[i] < tbl_age[slot])))
                            slot = i;
                    end
                    if (slot >= 0) begin
                        drop_slot(slot);
                        res.evicted = 1'b1;
                    end
                end
                slot = -1;
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (!tbl_valid[i]) begin
                        slot = i;
                        break;
                    end
                end
                if (slot >= 0) begin
                    for (int i = 0; i < TBL_DEPTH; i++) begin
                        if (tbl_valid[i])
                            tbl_age[i]++;
                    end
                    tbl_valid[slot]   = 1'b1;
                    tbl_key[slot]     = key;
                    tbl_payload[slot] = pay;
                    tbl_hits[slot]    = '0;
                    tbl_age[slot]     = 0;
                    tbl_fill++;
                    res.status = lfu_pkg::ST_OK;
                end
            end
            lfu_pkg::ACT_DEL: begin
                slot = newest_match(key);
                if (slot >= 0) begin
                    drop_slot(slot);
                    res.status = lfu_pkg::ST_OK;
                end
            end
            lfu_pkg::ACT_FIND: begin
                slot = newest_match(key);
                if (slot >= 0) begin
                    if (tbl_hits[slot] != HITS_FULL)
                        tbl_hits[slot]++;
                    res.payload = tbl_payload[slot];
                    res.status  = lfu_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: one request item per call
    // ------------------------------------------------------------------

    // Enter at or after a rising edge; drive at the falling edge, hold until accepted.
    task automatic send_request(logic [1:0] act, logic [31:0] key, logic [63:0] pay);
        t_lfu_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {pay, key};
        do @(posedge i_clk); while (!s_axis_tready);

        res = predict_request(act, key, pay);
        pending_results.push_back(res);
        if (act == lfu_pkg::ACT_ADD)
            add_count++;
        if (res.evicted)
            evict_count++;
        if (act == ACT_UNUSED)
            unused_count++;
        else if (act != lfu_pkg::ACT_ADD && res.status == lfu_pkg::ST_OK)
            hit_count++;
        else if (act != lfu_pkg::ACT_ADD)
            miss_count++;
    endtask

    function automatic logic [63:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    // Lower valid after the last item, then let every expected result drain
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // Stall the result stream at random; the knob is zero in the quiet phases
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_lfu_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected result item: status %0b payload %h evicted %0b",
                             m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[0] !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Result %0d status: expected %0b, got %0b",
                                 result_count, want.status, m_axis_tuser[0]);
                end
                if (m_axis_tdata !== want.payload) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Result %0d payload: expected %h, got %h",
                                 result_count, want.payload, m_axis_tdata);
                end
                if (m_axis_tuser[1] !== want.evicted) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Result %0d evicted: expected %0b, got %0b",
                                 result_count, want.evicted, m_axis_tuser[1]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty-table misses, the unused code, extreme keys and payloads, duplicates
    task automatic test_basic_requests();
        send_request(lfu_pkg::ACT_FIND, KEY_MIN, rand_payload());
        send_request(lfu_pkg::ACT_DEL, KEY_MAX, rand_payload());
        send_request(ACT_UNUSED, $urandom, rand_payload());
        send_request(lfu_pkg::ACT_ADD, KEY_MIN, {64{1'b1}});
        send_request(lfu_pkg::ACT_ADD, KEY_MAX, 64'd0);
        send_request(lfu_pkg::ACT_FIND, KEY_MIN, rand_payload());
        send_request(lfu_pkg::ACT_FIND, KEY_MAX, rand_payload());
        send_request(ACT_UNUSED, KEY_MIN, {64{1'b1}});
        // Duplicate keys: find and delete hit the newest copy first
        send_request(lfu_pkg::ACT_ADD, 32'd0, 64'hA5A5_A5A5_5A5A_5A5A);
        send_request(lfu_pkg::ACT_ADD, 32'd0, 64'h0123_4567_89AB_CDEF);
        send_request(lfu_pkg::ACT_FIND, 32'd0, rand_payload());
        send_request(lfu_pkg::ACT_DEL, 32'd0, rand_payload());
        send_request(lfu_pkg::ACT_FIND, 32'd0, rand_payload());
        send_request(lfu_pkg::ACT_DEL, 32'hFFFF_FFFF, rand_payload());
        send_request(lfu_pkg::ACT_DEL, KEY_MIN, rand_payload());
        send_request(lfu_pkg::ACT_FIND, KEY_MIN, rand_payload());
        drain_results();
    endtask

    // Fill the table, then add into it: ties evict the newest, popular entries survive
    task automatic test_full_table();
        for (int i = 0; i < TBL_DEPTH; i++)
            send_request(lfu_pkg::ACT_ADD, 32'd100 + i, rand_payload());
        send_request(lfu_pkg::ACT_ADD, 32'd200, rand_payload());
        send_request(lfu_pkg::ACT_FIND, 32'd100, rand_payload());
        send_request(lfu_pkg::ACT_FIND, 32'd105, rand_payload());
        send_request(lfu_pkg::ACT_FIND, 32'd105, rand_payload());
        send_request(lfu_pkg::ACT_ADD, 32'd201, rand_payload());
        send_request(lfu_pkg::ACT_ADD, 32'd202, rand_payload());
        send_request(lfu_pkg::ACT_FIND, 32'd200, rand_payload());
        send_request(lfu_pkg::ACT_FIND, 32'd101, rand_payload());
        drain_results();
    endtask

    // Hammer one key so it is the most popular, then evict around it
    task automatic test_popular_key();
        logic [31:0] key;
        key = $urandom;
        send_request(lfu_pkg::ACT_ADD, key, rand_payload());
        for (int i = 0; i < POPULAR_FINDS; i++)
            send_request(lfu_pkg::ACT_FIND, key, 64'd0);
        for (int i = 0; i < TBL_DEPTH + 2; i++)
            send_request(lfu_pkg::ACT_ADD, $urandom, rand_payload());
        send_request(lfu_pkg::ACT_FIND, key, rand_payload());
        drain_results();
    endtask

    // Mostly pooled keys so finds and deletes hit; some fully random keys as noise
    task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct);
        int unsigned pick;
        logic [31:0] key;
        logic [1:0]  act;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < RAND_ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(99) < 85)
                key = key_pool[$urandom_range(11)];
            else
                key = $urandom;
            pick = $urandom_range(99);
            if (pick < 40)
                act = lfu_pkg::ACT_ADD;
            else if (pick < 60)
                act = lfu_pkg::ACT_DEL;
            else if (pick < 95)
                act = lfu_pkg::ACT_FIND;
            else
                act = ACT_UNUSED;
            send_request(act, key, rand_payload());
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        for (int i = 0; i < TBL_DEPTH; i++)
            tbl_valid[i] = 1'b0;
        tbl_fill = 0;

        // More distinct keys than slots, so misses and refills stay common
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 32'd0;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 12; i++)
            key_pool[i] = $urandom;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed parts run with mild back-pressure; the popular-key run goes flat out
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        test_basic_requests();
        test_full_table();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_popular_key();

        test_random_traffic(0, 0);
        test_random_traffic(49, 0);
        test_random_traffic(0, 49);
        test_random_traffic(19, 19);

        // Catch any stray result item after the last expected one
        repeat (TBL_DEPTH + 6) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            mismatch_count += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("Checked %0d results: %0d adds (%0d evictions), %0d hits, %0d misses",
                 result_count, add_count, evict_count, hit_count, miss_count);
        $display("Unused-code requests: %0d; mismatches: %0d", unused_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
